@@ hdl/npsc_pkg.sv @@
package npsc_pkg;

    // Number of dimensions that the extent registers can describe.
    localparam int NUM_EXT_DIMS = 7;
    localparam int EXT_FIELD_W  = 16;
    localparam int ORD_BITS     = 3;

    localparam int RAW_W        = 32;
    localparam int SAMPLE_W     = 33;
    localparam int DEST_W       = 32;
    localparam int VALUE_W      = 48;
    localparam int SCALE_W      = 32;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;

    localparam int FIFO_DEPTH   = 4;
    localparam int MUL_CHUNK_W  = 16;

    localparam logic [63:0] EXTENTS_LOW_RST  = 64'h0001_0001_0001_0001;
    localparam logic [47:0] EXTENTS_HIGH_RST = 48'h0001_0001_0001;
    localparam logic [20:0] DIM_ORDER_RST    = 21'o6543210;

    // Source type: bit 0 is the sign, bits 2:1 the sample size.
    localparam logic [1:0] SRC_SIZE_8  = 2'd0;
    localparam logic [1:0] SRC_SIZE_16 = 2'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EXTENTS_LOW,
        REG_EXTENTS_HIGH,
        REG_DIM_ORDER,
        REG_SOURCE_TYPE,
        REG_SCALE,
        REG_OFFSET
    } cfg_reg_t;

    typedef struct packed {
        logic [DEST_W-1:0]          dest_address;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_element;
    } front_item_t;

    typedef struct packed {
        logic [DEST_W-1:0]         dest_address;
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
        logic                      last_element;
    } result_t;

endpackage

@@ hdl/npsc_fifo.sv @@
module npsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/npsc_stride.sv @@
module npsc_stride #(
    parameter int MAX_DIMS  = 7,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [MAX_DIMS-1:0][npsc_pkg::ORD_BITS-1:0]  ord,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]            ext,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]            ext_m1,
    output logic                                         busy,
    output logic [MAX_DIMS-1:0][ADDR_BITS-1:0]           delta
);

    localparam int CW    = npsc_pkg::MUL_CHUNK_W;
    localparam int NCH   = (ADDR_BITS + CW - 1) / CW;
    localparam int MB    = NCH * CW;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_STR_LD,
        S_STR_MUL,
        S_PRE_LD,
        S_PRE_MUL,
        S_SPAN_LD,
        S_SPAN_MUL
    } state_t;

    state_t                              state_reg, state_next;
    logic [IDX_W-1:0]                    idx_reg, idx_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]                mul_a_reg, mul_a_next;
    logic [MB-1:0]                       mul_b_reg, mul_b_next;
    logic [ADDR_BITS-1:0]                mul_acc_reg, mul_acc_next;
    logic [ADDR_BITS-1:0]                prefix_reg, prefix_next;
    logic [ADDR_BITS-1:0]                cum_reg, cum_next;
    logic [MAX_DIMS-1:0][ADDR_BITS-1:0]  stride_reg, stride_next;
    logic [MAX_DIMS-1:0][ADDR_BITS-1:0]  delta_reg, delta_next;

    logic [npsc_pkg::ORD_BITS-1:0]       e;
    logic                                e_valid;
    logic [IDX_W-1:0]                    e_ix;
    logic [IDX_W-1:0]                    rd_ix;
    logic [ADDR_BITS-1:0]                stride_rd;
    logic [DIM_BITS-1:0]                 ext_e;
    logic [ADDR_BITS+CW-1:0]             part;
    logic [ADDR_BITS-1:0]                acc_sum;
    logic                                mul_last;
    logic                                idx_last;

    assign busy  = (state_reg != S_IDLE);
    assign delta = delta_reg;

    // The order entry of the current step picks the dimension whose stride
    // takes the running prefix product.
    assign e         = ord[idx_reg];
    assign e_valid   = (int'(e) < MAX_DIMS);
    assign e_ix      = e[IDX_W-1:0];
    assign rd_ix     = (state_reg == S_SPAN_LD || state_reg == S_SPAN_MUL) ? idx_reg : e_ix;
    assign stride_rd = stride_reg[rd_ix];
    assign ext_e     = e_valid ? ext[e_ix] : DIM_BITS'(1);

    // One 16-bit slice of the multiplier operand per cycle, low product bits only.
    assign part     = mul_a_reg * mul_b_reg[CW-1:0];
    assign acc_sum  = mul_acc_reg + part[ADDR_BITS-1:0];
    assign mul_last = (cnt_reg == CNT_W'(NCH - 1));
    assign idx_last = (idx_reg == IDX_W'(MAX_DIMS - 1));

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_acc_next = mul_acc_reg;
        prefix_next  = prefix_reg;
        cum_next     = cum_reg;
        stride_next  = stride_reg;
        delta_next   = delta_reg;

        if (state_reg == S_STR_MUL || state_reg == S_PRE_MUL || state_reg == S_SPAN_MUL)
        begin
            mul_acc_next = acc_sum;
            mul_a_next   = mul_a_reg << CW;
            mul_b_next   = mul_b_reg >> CW;
            cnt_next     = cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_INIT:
            begin
                for (int k = 0; k < MAX_DIMS; k++)
                begin
                    stride_next[k] = ADDR_BITS'(1);
                end
                prefix_next = ADDR_BITS'(1);
                idx_next    = '0;
                state_next  = S_STR_LD;
            end
            S_STR_LD:
            begin
                mul_a_next   = stride_rd;
                mul_b_next   = MB'(prefix_reg);
                mul_acc_next = '0;
                cnt_next     = '0;
                state_next   = S_STR_MUL;
            end
            S_STR_MUL:
            begin
                if (mul_last)
                begin
                    if (e_valid)
                    begin
                        stride_next[e_ix] = acc_sum;
                    end
                    state_next = S_PRE_LD;
                end
            end
            S_PRE_LD:
            begin
                mul_a_next   = prefix_reg;
                mul_b_next   = MB'(ext_e);
                mul_acc_next = '0;
                cnt_next     = '0;
                state_next   = S_PRE_MUL;
            end
            S_PRE_MUL:
            begin
                if (mul_last)
                begin
                    prefix_next = acc_sum;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        cum_next   = '0;
                        state_next = S_SPAN_LD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_STR_LD;
                    end
                end
            end
            S_SPAN_LD:
            begin
                mul_a_next   = stride_rd;
                mul_b_next   = MB'(ext_m1[idx_reg]);
                mul_acc_next = '0;
                cnt_next     = '0;
                state_next   = S_SPAN_MUL;
            end
            S_SPAN_MUL:
            begin
                if (mul_last)
                begin
                    // Stepping this digit adds its stride and rewinds every
                    // lower digit from its last position to zero.
                    delta_next[idx_reg] = stride_rd - cum_reg;
                    cum_next            = cum_reg + acc_sum;
                    if (idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_SPAN_LD;
                    end
                end
            end
        endcase

        if (start)
        begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            mul_a_reg   <= '0;
            mul_b_reg   <= '0;
            mul_acc_reg <= '0;
            prefix_reg  <= '0;
            cum_reg     <= '0;
            stride_reg  <= '0;
            delta_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            mul_a_reg   <= mul_a_next;
            mul_b_reg   <= mul_b_next;
            mul_acc_reg <= mul_acc_next;
            prefix_reg  <= prefix_next;
            cum_reg     <= cum_next;
            stride_reg  <= stride_next;
            delta_reg   <= delta_next;
        end
    end

endmodule

@@ hdl/npsc_front.sv @@
module npsc_front #(
    parameter int MAX_DIMS  = 7,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clear,
    input  logic                                  accept,
    input  logic [npsc_pkg::RAW_W-1:0]            raw_sample,
    input  logic [2:0]                            source_type,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]     ext_m1,
    input  logic [MAX_DIMS-1:0][ADDR_BITS-1:0]    delta,
    output npsc_pkg::front_item_t                 item
);

    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [MAX_DIMS-1:0][DIM_BITS-1:0]  sub_reg, sub_next;
    logic [ADDR_BITS-1:0]               addr_reg, addr_next;
    logic [MAX_DIMS-1:0]                at_last;
    logic                               all_last;
    logic                               found;
    logic [IDX_W-1:0]                   sel;
    logic [ADDR_BITS+npsc_pkg::DEST_W-1:0] addr_ext;
    logic signed [npsc_pkg::SAMPLE_W-1:0]  sample;
    logic                               is_signed;

    assign is_signed = source_type[0];

    always_comb
    begin
        unique case (source_type[2:1])
            npsc_pkg::SRC_SIZE_8:
                sample = {{25{is_signed & raw_sample[7]}}, raw_sample[7:0]};
            npsc_pkg::SRC_SIZE_16:
                sample = {{17{is_signed & raw_sample[15]}}, raw_sample[15:0]};
            default:
                sample = {is_signed & raw_sample[31], raw_sample};
        endcase
    end

    // The lowest digit that is not at its last position is the one that steps.
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            at_last[d] = (sub_reg[d] >= ext_m1[d]);
            if (!found && !at_last[d])
            begin
                found = 1'b1;
                sel   = IDX_W'(d);
            end
        end
        all_last = &at_last;
    end

    always_comb
    begin
        sub_next  = sub_reg;
        addr_next = addr_reg;
        if (clear)
        begin
            sub_next  = '0;
            addr_next = '0;
        end
        else if (accept)
        begin
            addr_next = all_last ? '0 : addr_reg + delta[sel];
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (all_last || d < int'(sel))
                begin
                    sub_next[d] = '0;
                end
                else if (d == int'(sel))
                begin
                    sub_next[d] = sub_reg[d] + DIM_BITS'(1);
                end
            end
        end
    end

    assign addr_ext          = {{npsc_pkg::DEST_W{1'b0}}, addr_reg};
    assign item.dest_address = addr_ext[npsc_pkg::DEST_W-1:0];
    assign item.sample       = sample;
    assign item.last_element = all_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg  <= '0;
            addr_reg <= '0;
        end
        else
        begin
            sub_reg  <= sub_next;
            addr_reg <= addr_next;
        end
    end

endmodule

@@ hdl/npsc_back.sv @@
module npsc_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     mid_empty,
    input  npsc_pkg::front_item_t                    mid_item,
    output logic                                     mid_pop,
    input  logic signed [npsc_pkg::SCALE_W-1:0]      scale,
    input  logic signed [npsc_pkg::VALUE_W-1:0]      offset,
    input  logic                                     pop,
    output logic                                     empty,
    output npsc_pkg::result_t                        result
);

    localparam int PROD_W = npsc_pkg::SCALE_W + npsc_pkg::SAMPLE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(npsc_pkg::FIFO_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] PROD_LIMIT = 66'sh1000000000000000;
    localparam logic signed [SUM_W-1:0] Q_MAX      = 66'sh7FFFFFFFFFFF;
    localparam logic signed [SUM_W-1:0] Q_MIN      = -66'sh800000000000;

    logic                                    v1_reg;
    logic signed [PROD_W-1:0]                p1_reg;
    logic                                    byp1_reg;
    logic [npsc_pkg::DEST_W-1:0]             addr1_reg;
    logic                                    last1_reg;

    logic                                    bypass;
    logic signed [PROD_W-1:0]                prod;
    logic signed [SUM_W-1:0]                 p_ext;
    logic signed [SUM_W-1:0]                 clamped;
    logic signed [SUM_W-1:0]                 sum;
    npsc_pkg::result_t                       wr_item;
    logic [CNT_W-1:0]                        out_count;
    logic [$bits(npsc_pkg::result_t)-1:0]    out_rdata;

    // Pull from the queue only with room reserved for the item in flight.
    assign mid_pop = !mid_empty &&
                     ((int'(out_count) + int'(v1_reg)) < npsc_pkg::FIFO_DEPTH);

    assign bypass = (scale == '0) ||
                    (scale == 32'sh0001_0000 && offset == '0);

    always_comb
    begin
        if (bypass)
        begin
            prod = PROD_W'(mid_item.sample) <<< 16;
        end
        else
        begin
            prod = scale * mid_item.sample;
        end
    end

    always_comb
    begin
        p_ext = SUM_W'(p1_reg);
        if (p_ext > PROD_LIMIT)
        begin
            clamped = PROD_LIMIT;
        end
        else if (p_ext < -PROD_LIMIT)
        begin
            clamped = -PROD_LIMIT;
        end
        else
        begin
            clamped = p_ext;
        end
        sum = byp1_reg ? p_ext : clamped + SUM_W'(offset);

        wr_item.dest_address = addr1_reg;
        wr_item.last_element = last1_reg;
        if (sum > Q_MAX)
        begin
            wr_item.value     = Q_MAX[npsc_pkg::VALUE_W-1:0];
            wr_item.saturated = 1'b1;
        end
        else if (sum < Q_MIN)
        begin
            wr_item.value     = Q_MIN[npsc_pkg::VALUE_W-1:0];
            wr_item.saturated = 1'b1;
        end
        else
        begin
            wr_item.value     = sum[npsc_pkg::VALUE_W-1:0];
            wr_item.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= mid_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            p1_reg    <= prod;
            byp1_reg  <= bypass;
            addr1_reg <= mid_item.dest_address;
            last1_reg <= mid_item.last_element;
        end
    end

    npsc_fifo #(
        .WIDTH ($bits(npsc_pkg::result_t)),
        .DEPTH (npsc_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (v1_reg),
        .wdata (wr_item),
        .full  (),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign result = npsc_pkg::result_t'(out_rdata);

endmodule

@@ hdl/nd_permute_scale_convert.sv @@
// Path: mid FIFO, scaling register, output FIFO; its head drives the result ports.
// Throughput: one item per cycle, sustained while pop keeps up and geometry is idle.
// Reset: registers take their defaults, subscripts and address clear, and the stride
// sequencer steps through its init, stride, prefix and span states with full held
// high. The same sequence follows every extents or dim_order write.
module nd_permute_scale_convert #(
    parameter int MAX_DIMS  = 7,
    parameter int DIM_BITS  = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [npsc_pkg::RAW_W-1:0]             raw_sample,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [npsc_pkg::DEST_W-1:0]            dest_address,
    output logic signed [npsc_pkg::VALUE_W-1:0]    value,
    output logic                                   saturated,
    output logic                                   last_element,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [npsc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [npsc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [63:0]                                 extents_low_reg;
    logic [47:0]                                 extents_high_reg;
    logic [20:0]                                 dim_order_reg;
    logic [2:0]                                  source_type_reg;
    logic signed [npsc_pkg::SCALE_W-1:0]         scale_reg;
    logic signed [npsc_pkg::VALUE_W-1:0]         offset_reg;

    logic                                        cfg_wr;
    logic                                        geom_wr;
    logic [111:0]                                ext_all;
    logic [MAX_DIMS-1:0][npsc_pkg::ORD_BITS-1:0] ord;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]           ext;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]           ext_m1;
    logic [MAX_DIMS-1:0][ADDR_BITS-1:0]          delta;
    logic                                        geom_busy;
    logic                                        in_accept;
    logic                                        mid_full;
    logic                                        mid_empty;
    logic                                        mid_pop;
    npsc_pkg::front_item_t                       front_item;
    logic [$bits(npsc_pkg::front_item_t)-1:0]    mid_rdata;
    npsc_pkg::result_t                           result;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr &&
                       (npsc_pkg::cfg_reg_t'(cfg_index) == npsc_pkg::REG_EXTENTS_LOW ||
                        npsc_pkg::cfg_reg_t'(cfg_index) == npsc_pkg::REG_EXTENTS_HIGH ||
                        npsc_pkg::cfg_reg_t'(cfg_index) == npsc_pkg::REG_DIM_ORDER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extents_low_reg  <= npsc_pkg::EXTENTS_LOW_RST;
            extents_high_reg <= npsc_pkg::EXTENTS_HIGH_RST;
            dim_order_reg    <= npsc_pkg::DIM_ORDER_RST;
            source_type_reg  <= '0;
            scale_reg        <= '0;
            offset_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (npsc_pkg::cfg_reg_t'(cfg_index))
                npsc_pkg::REG_EXTENTS_LOW:  extents_low_reg  <= cfg_data;
                npsc_pkg::REG_EXTENTS_HIGH: extents_high_reg <= cfg_data[47:0];
                npsc_pkg::REG_DIM_ORDER:    dim_order_reg    <= cfg_data[20:0];
                npsc_pkg::REG_SOURCE_TYPE:  source_type_reg  <= cfg_data[2:0];
                npsc_pkg::REG_SCALE:        scale_reg        <= cfg_data[npsc_pkg::SCALE_W-1:0];
                npsc_pkg::REG_OFFSET:       offset_reg       <= cfg_data[npsc_pkg::VALUE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A zero extent counts as one; dimensions without a register have extent one.
    assign ext_all = {extents_high_reg, extents_low_reg};

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_dim
        if (d < npsc_pkg::NUM_EXT_DIMS)
        begin : g_reg
            logic [DIM_BITS-1:0] raw_ext;
            assign raw_ext   = ext_all[npsc_pkg::EXT_FIELD_W*d +: DIM_BITS];
            assign ext[d]    = (raw_ext == '0) ? DIM_BITS'(1) : raw_ext;
            assign ext_m1[d] = ext[d] - DIM_BITS'(1);
            assign ord[d]    = dim_order_reg[npsc_pkg::ORD_BITS*d +: npsc_pkg::ORD_BITS];
        end
        else
        begin : g_fixed
            assign ext[d]    = DIM_BITS'(1);
            assign ext_m1[d] = '0;
            assign ord[d]    = npsc_pkg::ORD_BITS'(d);
        end
    end

    npsc_stride #(
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_stride (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (geom_wr),
        .ord    (ord),
        .ext    (ext),
        .ext_m1 (ext_m1),
        .busy   (geom_busy),
        .delta  (delta)
    );

    assign full      = mid_full || geom_busy;
    assign in_accept = push && !full;

    npsc_front #(
        .MAX_DIMS  (MAX_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (geom_wr),
        .accept      (in_accept),
        .raw_sample  (raw_sample),
        .source_type (source_type_reg),
        .ext_m1      (ext_m1),
        .delta       (delta),
        .item        (front_item)
    );

    npsc_fifo #(
        .WIDTH ($bits(npsc_pkg::front_item_t)),
        .DEPTH (npsc_pkg::FIFO_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_accept),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count ()
    );

    npsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (npsc_pkg::front_item_t'(mid_rdata)),
        .mid_pop   (mid_pop),
        .scale     (scale_reg),
        .offset    (offset_reg),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign dest_address = result.dest_address;
    assign value        = result.value;
    assign saturated    = result.saturated;
    assign last_element = result.last_element;

endmodule
